// ===== sv/rhcf_pkg.sv =====
`default_nettype none

package rhcf_pkg;

  // Window and buffer limits
  localparam int WINDOW_LEN = 7;
  localparam int MAX_BUFFER = 65536;
  localparam int PTR_W      = $clog2(WINDOW_LEN);

  // Field widths
  localparam int DATA_W   = 8;
  localparam int LEN_W    = 17;
  localparam int OFFSET_W = 16;
  localparam int SIZE_W   = 17;
  localparam int HASH_W   = 64;
  localparam int DIV_W    = 16;
  localparam int SKIP_W   = 12;
  localparam int ROLL_W   = 32;
  localparam int SHIFT    = 5;

  // Position arithmetic: must hold MAX_BUFFER + 1 and at least the size field
  localparam int POS_RAW_W = $clog2(MAX_BUFFER + 2);
  localparam int POS_W     = (POS_RAW_W > SIZE_W) ? POS_RAW_W : SIZE_W;

  // FNV-1a 64: prime = 2^40 + 0x1b3
  localparam logic [HASH_W-1:0] FNV_BASIS    = 64'hcbf29ce484222325;
  localparam int                FNV_HI_SHIFT = 40;
  localparam logic [HASH_W-1:0] FNV_PRIME_LO = 64'h1b3;

  // Input queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Remainder unit: radix-2, several bits per cycle
  localparam int DIV_BITS_PER_CYCLE = 4;
  localparam int DIV_ITER           = ROLL_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_ITER);

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_DIVISOR = 2'd0,
    REG_SKIP_COUNT    = 2'd1,
    REG_NETWORK_MODE  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DIV_W-1:0]  block_divisor;
    logic [SKIP_W-1:0] skip_count;
    logic              network_mode;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  buffer_length;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    logic [HASH_W-1:0]   chunk_hash;
    logic [OFFSET_W-1:0] chunk_offset;
    logic [SIZE_W-1:0]   chunk_size;
    logic                end_of_buffer;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [ROLL_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  // One FNV-1a byte step; the prime multiply is a shift plus a 9-bit constant
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [DATA_W-1:0] c);
    logic [HASH_W-1:0] x;
    x = h ^ HASH_W'(c);
    return (x << FNV_HI_SHIFT) + x * FNV_PRIME_LO;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rhcf_front.sv =====
`default_nettype none

module rhcf_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rhcf_pkg::item_t in_item,
  output logic                q_valid,
  output rhcf_pkg::item_t     q_item,
  input  wire logic           q_pop
);

  rhcf_pkg::item_t                  mem [rhcf_pkg::QUEUE_DEPTH];
  logic [rhcf_pkg::QPTR_W-1:0]      wr_ptr;
  logic [rhcf_pkg::QPTR_W-1:0]      rd_ptr;
  logic [rhcf_pkg::QCNT_W-1:0]      count;
  logic                             push;
  logic                             pop;

  assign in_stall = (count == rhcf_pkg::QCNT_W'(rhcf_pkg::QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == rhcf_pkg::QPTR_W'(rhcf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == rhcf_pkg::QPTR_W'(rhcf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/rhcf_divmod.sv =====
`default_nettype none

module rhcf_divmod (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rhcf_pkg::div_req_t req,
  output rhcf_pkg::div_rsp_t      rsp
);

  logic                              busy;
  logic [rhcf_pkg::DIV_CNT_W-1:0]    cnt;
  logic [rhcf_pkg::ROLL_W-1:0]       num;
  logic [rhcf_pkg::DIV_W-1:0]        rem;
  logic [rhcf_pkg::DIV_W-1:0]        dvs;
  logic                              done;
  logic [rhcf_pkg::ROLL_W-1:0]       num_next;
  logic [rhcf_pkg::DIV_W-1:0]        rem_next;

  // DIV_BITS_PER_CYCLE restoring steps per clock
  always_comb begin
    logic [rhcf_pkg::DIV_W:0] t;
    num_next = num;
    rem_next = rem;
    for (int i = 0; i < rhcf_pkg::DIV_BITS_PER_CYCLE; i++) begin
      t        = {rem_next, num_next[rhcf_pkg::ROLL_W-1]};
      num_next = num_next << 1;
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
      end
      rem_next = t[rhcf_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      num  <= '0;
      rem  <= '0;
      dvs  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        num <= num_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == rhcf_pkg::DIV_CNT_W'(rhcf_pkg::DIV_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

// ===== sv/rhcf_back.sv =====
`default_nettype none

module rhcf_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rhcf_pkg::cfg_t       cfg,
  input  wire logic                 q_valid,
  input  wire rhcf_pkg::item_t      q_item,
  output logic                      q_pop,
  output rhcf_pkg::div_req_t        div_req,
  input  wire rhcf_pkg::div_rsp_t   div_rsp,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rhcf_pkg::result_t         out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DECIDE,
    S_EMIT_A,
    S_EMIT_B
  } state_t;

  localparam int PW = rhcf_pkg::POS_W;

  state_t                             state;

  // rolling and per-buffer state
  logic [rhcf_pkg::DATA_W-1:0]        window [rhcf_pkg::WINDOW_LEN];
  logic [rhcf_pkg::PTR_W-1:0]         window_ptr;
  logic [rhcf_pkg::ROLL_W-1:0]        window_sum;
  logic [rhcf_pkg::ROLL_W-1:0]        weighted_sum;
  logic [rhcf_pkg::ROLL_W-1:0]        shift_xor;
  logic [PW-1:0]                      byte_pos;
  logic [PW-1:0]                      chunk_start;
  logic [rhcf_pkg::SKIP_W-1:0]        skip_left;
  logic [rhcf_pkg::HASH_W-1:0]        chunk_fnv;
  logic                               first_pending;

  // current word
  logic [PW-1:0]                      cur_pos;
  logic [rhcf_pkg::LEN_W-1:0]         cur_len;
  logic                               cur_last;
  logic                               cur_rolled;

  logic                               div_start;
  logic [rhcf_pkg::ROLL_W-1:0]        div_dividend;

  rhcf_pkg::result_t                  res_a;
  rhcf_pkg::result_t                  res_b;
  logic                               have_b;

  logic                               out_free;

  // roll datapath
  logic [rhcf_pkg::ROLL_W-1:0]        c32;
  logic [rhcf_pkg::ROLL_W-1:0]        ws_new;
  logic [rhcf_pkg::ROLL_W-1:0]        wt_new;
  logic [rhcf_pkg::ROLL_W-1:0]        sx_new;
  logic [rhcf_pkg::PTR_W-1:0]         ptr_next;
  logic [PW-1:0]                      pos_inc;

  // decision datapath
  logic                               boundary;
  logic                               d_have_a;
  logic                               d_have_b;
  rhcf_pkg::result_t                  d_res_a;
  rhcf_pkg::result_t                  d_res_b;
  logic [PW-1:0]                      d_cs;
  logic [rhcf_pkg::HASH_W-1:0]        d_fnv;
  logic                               d_first;
  logic [rhcf_pkg::SKIP_W-1:0]        d_skip;
  logic [PW-1:0]                      pos_plus1;
  logic [PW-1:0]                      size_a;
  logic [PW-1:0]                      size_b;
  logic                               skip_fits;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    c32    = rhcf_pkg::ROLL_W'(q_item.data_byte);
    ws_new = window_sum + c32 - rhcf_pkg::ROLL_W'(window[window_ptr]);
    wt_new = weighted_sum - window_sum
           + rhcf_pkg::ROLL_W'(rhcf_pkg::WINDOW_LEN) * c32;
    sx_new = (shift_xor << rhcf_pkg::SHIFT) ^ c32;
    ptr_next = (window_ptr == rhcf_pkg::PTR_W'(rhcf_pkg::WINDOW_LEN - 1)) ? '0
                                                                           : window_ptr + 1'b1;
    pos_inc = (byte_pos < PW'(rhcf_pkg::MAX_BUFFER)) ? byte_pos + 1'b1 : byte_pos;
  end

  always_comb begin
    boundary  = cur_rolled && (cfg.block_divisor != '0)
             && (div_rsp.rem == cfg.block_divisor - 1'b1);
    pos_plus1 = cur_pos + 1'b1;
    size_a    = cur_pos - chunk_start + 1'b1;
    skip_fits = ({1'b0, cur_pos} + (PW+1)'(cfg.skip_count)) < (PW+1)'(cur_len);

    d_cs     = chunk_start;
    d_fnv    = chunk_fnv;
    d_first  = first_pending;
    d_skip   = skip_left;
    d_have_a = 1'b0;
    d_res_a  = '{chunk_hash:    chunk_fnv,
                 chunk_offset:  chunk_start[rhcf_pkg::OFFSET_W-1:0],
                 chunk_size:    size_a[rhcf_pkg::SIZE_W-1:0],
                 end_of_buffer: 1'b0};

    if (boundary) begin
      if (cfg.network_mode && first_pending) begin
        d_first = 1'b0;
      end else begin
        d_have_a = 1'b1;
      end
      d_fnv = rhcf_pkg::FNV_BASIS;
      d_cs  = pos_plus1;
      if (skip_fits) begin
        d_skip = cfg.skip_count;
      end
    end

    // tail chunk uses post-boundary start and hash
    size_b   = (pos_plus1 >= d_cs) ? pos_plus1 - d_cs : '0;
    d_have_b = 1'b0;
    d_res_b  = '{chunk_hash:    d_fnv,
                 chunk_offset:  d_cs[rhcf_pkg::OFFSET_W-1:0],
                 chunk_size:    size_b[rhcf_pkg::SIZE_W-1:0],
                 end_of_buffer: 1'b1};
    if (cur_last) begin
      if (!cfg.network_mode) begin
        d_have_b = 1'b1;
      end else if (d_have_a) begin
        d_res_a.end_of_buffer = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      for (int i = 0; i < rhcf_pkg::WINDOW_LEN; i++) begin
        window[i] <= '0;
      end
      window_ptr    <= '0;
      window_sum    <= '0;
      weighted_sum  <= '0;
      shift_xor     <= '0;
      byte_pos      <= '0;
      chunk_start   <= '0;
      skip_left     <= '0;
      chunk_fnv     <= rhcf_pkg::FNV_BASIS;
      first_pending <= 1'b1;
      div_start     <= 1'b0;
      out_valid     <= 1'b0;
      have_b        <= 1'b0;
      cur_rolled    <= 1'b0;
      cur_last      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            chunk_fnv <= rhcf_pkg::fnv_step(chunk_fnv, q_item.data_byte);
            cur_pos   <= byte_pos;
            cur_len   <= q_item.buffer_length;
            cur_last  <= q_item.last_byte;
            byte_pos  <= pos_inc;
            if (skip_left != '0) begin
              skip_left  <= skip_left - 1'b1;
              cur_rolled <= 1'b0;
              state      <= S_DECIDE;
            end else begin
              window[window_ptr] <= q_item.data_byte;
              window_ptr   <= ptr_next;
              window_sum   <= ws_new;
              weighted_sum <= wt_new;
              shift_xor    <= sx_new;
              div_dividend <= ws_new + wt_new + sx_new;
              div_start    <= 1'b1;
              cur_rolled   <= 1'b1;
              state        <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          res_a  <= d_res_a;
          res_b  <= d_res_b;
          have_b <= d_have_b;
          if (cur_last) begin
            for (int i = 0; i < rhcf_pkg::WINDOW_LEN; i++) begin
              window[i] <= '0;
            end
            window_ptr    <= '0;
            window_sum    <= '0;
            weighted_sum  <= '0;
            shift_xor     <= '0;
            byte_pos      <= '0;
            chunk_start   <= '0;
            skip_left     <= '0;
            chunk_fnv     <= rhcf_pkg::FNV_BASIS;
            first_pending <= 1'b1;
          end else begin
            chunk_start   <= d_cs;
            chunk_fnv     <= d_fnv;
            first_pending <= d_first;
            skip_left     <= d_skip;
          end
          if (d_have_a) begin
            state <= S_EMIT_A;
          end else if (d_have_b) begin
            state <= S_EMIT_B;
          end else begin
            state <= S_IDLE;
          end
        end

        S_EMIT_A: begin
          if (out_free) begin
            out_res   <= res_a;
            out_valid <= 1'b1;
            state     <= have_b ? S_EMIT_B : S_IDLE;
          end
        end

        S_EMIT_B: begin
          if (out_free) begin
            out_res   <= res_b;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign div_req.start    = div_start;
  assign div_req.dividend = div_dividend;
  assign div_req.divisor  = cfg.block_divisor;

endmodule

`default_nettype wire

// ===== sv/rolling_hash_chunk_fingerprinter.sv =====
// Content-defined chunker. Bytes of a buffer arrive one word at a time on the
// input channel (last_byte marks the end of the buffer); each chunk found comes
// out as one word carrying its 64-bit FNV-1a hash, its offset and its size, and
// end_of_buffer flags the final chunk of a buffer. A rolling hash over the last
// WINDOW_LEN rolled bytes (window sum + weighted sum + shift-xor, 32-bit wrap)
// places a cut where hash mod block_divisor == block_divisor - 1; after a cut
// the next skip_count bytes join the chunk without being rolled, when they fit
// within buffer_length. In plain mode a tail chunk (possibly empty) closes
// every buffer; with network_mode set the first chunk of each buffer is
// dropped and no tail chunk is sent. A divisor of zero never cuts. A rolled
// byte waits on the iterative remainder unit, which retires 4 quotient bits
// per cycle; a skipped byte does not. The block finishes a byte before taking
// the next; a two-entry input queue keeps taking bytes meanwhile until it is
// full, and the output register holds a finished chunk while the next byte is
// already being processed. Config registers are written on cfg_write with
// cfg_index 0 = block_divisor, 1 = skip_count, 2 = network_mode; the user must
// write them only while the block is idle; the block does not enforce this.

`default_nettype none

module rolling_hash_chunk_fingerprinter (
  input  wire logic                                  clk,
  input  wire logic                                  rst,

  // config write port
  input  wire logic                                  cfg_write,
  input  wire logic [rhcf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [rhcf_pkg::CFG_DATA_W-1:0]       cfg_data,

  // byte input
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [rhcf_pkg::DATA_W-1:0]           data_byte,
  input  wire logic [rhcf_pkg::LEN_W-1:0]            buffer_length,
  input  wire logic                                  last_byte,

  // chunk output
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [rhcf_pkg::HASH_W-1:0]                chunk_hash,
  output logic [rhcf_pkg::OFFSET_W-1:0]              chunk_offset,
  output logic [rhcf_pkg::SIZE_W-1:0]                chunk_size,
  output logic                                       end_of_buffer
);

  rhcf_pkg::cfg_t      cfg;
  rhcf_pkg::item_t     in_item;
  rhcf_pkg::item_t     q_item;
  logic                q_valid;
  logic                q_pop;
  rhcf_pkg::div_req_t  div_req;
  rhcf_pkg::div_rsp_t  div_rsp;
  rhcf_pkg::result_t   out_res;

  // Config registers, reset to 320 / 64 / plain mode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_divisor <= rhcf_pkg::DIV_W'(320);
      cfg.skip_count    <= rhcf_pkg::SKIP_W'(64);
      cfg.network_mode  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rhcf_pkg::REG_BLOCK_DIVISOR: cfg.block_divisor <= cfg_data[rhcf_pkg::DIV_W-1:0];
        rhcf_pkg::REG_SKIP_COUNT:    cfg.skip_count    <= cfg_data[rhcf_pkg::SKIP_W-1:0];
        rhcf_pkg::REG_NETWORK_MODE:  cfg.network_mode  <= cfg_data[0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

  assign in_item.data_byte     = data_byte;
  assign in_item.buffer_length = buffer_length;
  assign in_item.last_byte     = last_byte;

  // Front: input queue
  rhcf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Iterative remainder of the rolling hash by block_divisor
  rhcf_divmod u_divmod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Back: rolling state, cut decision, chunk bookkeeping, output register
  rhcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign chunk_hash    = out_res.chunk_hash;
  assign chunk_offset  = out_res.chunk_offset;
  assign chunk_size    = out_res.chunk_size;
  assign end_of_buffer = out_res.end_of_buffer;

endmodule

`default_nettype wire

// ===== tb/rolling_hash_chunk_fingerprinter_tb.sv =====
module rolling_hash_chunk_fingerprinter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // FNV-1a 64-bit multiplier, kept local to the scoreboard
  localparam logic [63:0] FNV_MUL = 64'h0000_0100_0000_01b3;
  // Index 3 has no register behind it; writes there must be ignored
  localparam logic [rhcf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // Worst case for the block to finish what it already holds: two queued bytes plus
  // one in flight, plus the chunk words they may send
  localparam int SETTLE = 80;
  localparam int RANDOM_TARGET = 1350;
  localparam int LIMIT = 2_000_000;

  logic                                clk;
  logic                                rst;
  logic                                cfg_write;
  logic [rhcf_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [rhcf_pkg::CFG_DATA_W-1:0]     cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic [rhcf_pkg::DATA_W-1:0]         data_byte;
  logic [rhcf_pkg::LEN_W-1:0]          buffer_length;
  logic                                last_byte;
  logic                                out_valid;
  logic                                out_stall;
  logic [rhcf_pkg::HASH_W-1:0]         chunk_hash;
  logic [rhcf_pkg::OFFSET_W-1:0]       chunk_offset;
  logic [rhcf_pkg::SIZE_W-1:0]         chunk_size;
  logic                                end_of_buffer;

  rolling_hash_chunk_fingerprinter u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .buffer_length (buffer_length),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .chunk_hash    (chunk_hash),
    .chunk_offset  (chunk_offset),
    .chunk_size    (chunk_size),
    .end_of_buffer (end_of_buffer)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Chunker shadow: configuration and per-buffer state, at the block's widths
  // ---------------------------------------------------------------------------
  rhcf_pkg::cfg_t                      cfg_now;
  logic [rhcf_pkg::DATA_W-1:0]         win_bytes [rhcf_pkg::WINDOW_LEN];
  logic [rhcf_pkg::ROLL_W-1:0]         win_sum;
  logic [rhcf_pkg::ROLL_W-1:0]         weight_sum;
  logic [rhcf_pkg::ROLL_W-1:0]         shx_term;
  logic [rhcf_pkg::PTR_W-1:0]          win_ptr;
  logic [rhcf_pkg::POS_W-1:0]          pos_cnt;
  logic [rhcf_pkg::POS_W-1:0]          chunk_base;
  logic [rhcf_pkg::SKIP_W-1:0]         skip_rem;
  logic [rhcf_pkg::HASH_W-1:0]         fnv_acc;
  logic                                first_open;

  rhcf_pkg::result_t   made [2];     // chunk words caused by the current byte
  rhcf_pkg::result_t   chunks_due [$];
  int                  errors;
  int                  random_bytes;
  int                  cycle_cnt;
  logic                calm;         // no gaps and no stalls while set

  // Pinned expectation, driven alongside the payload so it lines up with the word
  int                  pin_n;
  rhcf_pkg::result_t   pin_a;
  rhcf_pkg::result_t   pin_b;

  function automatic void clear_buffer();
    for (int k = 0; k < rhcf_pkg::WINDOW_LEN; k++) win_bytes[k] = '0;
    win_sum    = '0;
    weight_sum = '0;
    shx_term   = '0;
    win_ptr    = '0;
    pos_cnt    = '0;
    chunk_base = '0;
    skip_rem   = '0;
    fnv_acc    = rhcf_pkg::FNV_BASIS;
    first_open = 1'b1;
  endfunction

  // Advance the chunker by one byte; returns how many chunk words it causes (in made[])
  function automatic int fold_byte(input rhcf_pkg::item_t it);
    logic [rhcf_pkg::ROLL_W-1:0] c;
    logic [rhcf_pkg::ROLL_W-1:0] h;
    logic [rhcf_pkg::ROLL_W-1:0] div;
    logic [rhcf_pkg::POS_W-1:0]  pos;
    logic [rhcf_pkg::POS_W-1:0]  tail_end;
    logic [rhcf_pkg::POS_W-1:0]  tail_size;
    int                          n;
    c   = rhcf_pkg::ROLL_W'(it.data_byte);
    div = rhcf_pkg::ROLL_W'(cfg_now.block_divisor);
    pos = pos_cnt;
    n   = 0;
    fnv_acc = (fnv_acc ^ rhcf_pkg::HASH_W'(it.data_byte)) * FNV_MUL;
    if (skip_rem != '0) begin
      skip_rem = skip_rem - 1'b1;
    end else begin
      weight_sum = weight_sum - win_sum + rhcf_pkg::ROLL_W'(rhcf_pkg::WINDOW_LEN) * c;
      win_sum    = win_sum + c - rhcf_pkg::ROLL_W'(win_bytes[win_ptr]);
      win_bytes[win_ptr] = it.data_byte;
      win_ptr    = (win_ptr == rhcf_pkg::PTR_W'(rhcf_pkg::WINDOW_LEN - 1)) ? '0
                                                                          : win_ptr + 1'b1;
      shx_term   = (shx_term << rhcf_pkg::SHIFT) ^ c;
      h          = win_sum + weight_sum + shx_term;
      // zero divisor never cuts
      if (div != '0 && (h % div) == div - 1) begin
        if (cfg_now.network_mode && first_open) begin
          first_open = 1'b0;  // network mode swallows the first chunk
        end else begin
          made[n] = '{fnv_acc, chunk_base[rhcf_pkg::OFFSET_W-1:0],
                      rhcf_pkg::SIZE_W'(pos - chunk_base + 1'b1), 1'b0};
          n++;
        end
        fnv_acc    = rhcf_pkg::FNV_BASIS;
        chunk_base = pos + 1'b1;
        // skip only if it stays inside the stated length (length 0 never skips)
        if (32'(pos) + 32'(cfg_now.skip_count) < 32'(it.buffer_length))
          skip_rem = cfg_now.skip_count;
      end
    end
    if (pos_cnt < rhcf_pkg::POS_W'(rhcf_pkg::MAX_BUFFER)) pos_cnt = pos_cnt + 1'b1;
    if (it.last_byte) begin
      if (!cfg_now.network_mode) begin
        // tail chunk, possibly empty
        tail_end  = pos + 1'b1;
        tail_size = (tail_end >= chunk_base) ? tail_end - chunk_base : '0;
        made[n] = '{fnv_acc, chunk_base[rhcf_pkg::OFFSET_W-1:0],
                    rhcf_pkg::SIZE_W'(tail_size), 1'b1};
        n++;
      end else if (n > 0) begin
        made[n-1].end_of_buffer = 1'b1;
      end
      clear_buffer();
    end
    return n;
  endfunction

  task automatic flag_chunk_error(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
    errors++;
    $display("%0t chunk mismatch on %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Monitors: predict on every accepted byte word, check every accepted chunk word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rhcf_pkg::item_t   seen;
    rhcf_pkg::result_t want;
    int                n;
    if (!rst && in_valid && !in_stall) begin
      seen.data_byte     = data_byte;
      seen.buffer_length = buffer_length;
      seen.last_byte     = last_byte;
      n = fold_byte(seen);
      // hand-typed rows replace the shadow's words; the shadow state still advances
      if (pin_n >= 0) begin
        n = pin_n;
        made[0] = pin_a;
        made[1] = pin_b;
      end
      for (int k = 0; k < n; k++) chunks_due.push_back(made[k]);
    end
    if (!rst && out_valid && !out_stall) begin
      if (chunks_due.size() == 0) begin
        flag_chunk_error("unexpected word", chunk_hash, '0);
      end else begin
        want = chunks_due.pop_front();
        if (chunk_hash !== want.chunk_hash)
          flag_chunk_error("chunk_hash", chunk_hash, want.chunk_hash);
        if (chunk_offset !== want.chunk_offset)
          flag_chunk_error("chunk_offset", 64'(chunk_offset), 64'(want.chunk_offset));
        if (chunk_size !== want.chunk_size)
          flag_chunk_error("chunk_size", 64'(chunk_size), 64'(want.chunk_size));
        if (end_of_buffer !== want.end_of_buffer)
          flag_chunk_error("end_of_buffer", 64'(end_of_buffer), 64'(want.end_of_buffer));
      end
    end
  end

  // Mostly short runs, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output back-pressure: runs of stall / no-stall of random length
  int stall_cnt;
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_cnt <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Present one byte word and hold it until it is taken
  task automatic send_byte(input logic [rhcf_pkg::DATA_W-1:0] d,
                           input logic [rhcf_pkg::LEN_W-1:0] blen,
                           input logic lst, input int npin, input rhcf_pkg::result_t pa,
                           input rhcf_pkg::result_t pb);
    in_valid      <= 1'b1;
    data_byte     <= d;
    buffer_length <= blen;
    last_byte     <= lst;
    pin_n         <= npin;
    pin_a         <= pa;
    pin_b         <= pb;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap();
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stop sending until every chunk word already owed has come out
  task automatic drain_chunks();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chunks_due.size() != 0) @(posedge clk);
  endtask

  // Drain, then give bytes that cause no chunk time to retire
  task automatic settle_block();
    drain_chunks();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rhcf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rhcf_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      rhcf_pkg::REG_BLOCK_DIVISOR: cfg_now.block_divisor = val;
      rhcf_pkg::REG_SKIP_COUNT:    cfg_now.skip_count    = val[rhcf_pkg::SKIP_W-1:0];
      rhcf_pkg::REG_NETWORK_MODE:  cfg_now.network_mode  = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One random buffer; the stated length usually matches, sometimes not
  task automatic send_buffer(input int nbytes);
    logic [rhcf_pkg::LEN_W-1:0] stated;
    case ($urandom_range(0, 9))
      0:       stated = rhcf_pkg::LEN_W'($urandom_range(0, (1 << rhcf_pkg::LEN_W) - 1));
      1:       stated = rhcf_pkg::LEN_W'($urandom_range(0, nbytes));
      default: stated = rhcf_pkg::LEN_W'(nbytes);
    endcase
    for (int k = 0; k < nbytes; k++) begin
      send_byte(rhcf_pkg::DATA_W'($urandom_range(0, 255)), stated, k == nbytes - 1, -1,
                '0, '0);
      random_bytes++;
      idle_gap();
      if ($urandom_range(0, 199) == 0) drain_chunks();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef enum {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [rhcf_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [rhcf_pkg::CFG_DATA_W-1:0] reg_val;
    logic [rhcf_pkg::DATA_W-1:0]     d;
    logic [rhcf_pkg::LEN_W-1:0]      blen;
    logic                            lst;
    int                              npin;     // -1: let the shadow predict
    rhcf_pkg::result_t               pa;
    rhcf_pkg::result_t               pb;
  } stim_row_t;

  stim_row_t stim_rows [$];

  function automatic void add_byte(input logic [rhcf_pkg::DATA_W-1:0] d,
                                   input logic [rhcf_pkg::LEN_W-1:0] blen,
                                   input logic lst, input int npin = -1,
                                   input rhcf_pkg::result_t pa = '0,
                                   input rhcf_pkg::result_t pb = '0);
    stim_row_t r;
    r.kind    = ROW_BYTE;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.d       = d;
    r.blen    = blen;
    r.lst     = lst;
    r.npin    = npin;
    r.pa      = pa;
    r.pb      = pb;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [rhcf_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rhcf_pkg::CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '{ROW_CFG, idx, val, '0, '0, 1'b0, -1, '0, '0};
    stim_rows.push_back(r);
  endfunction

  function automatic void build_table();
    // reset settings: one zero byte never cuts, so one tail word
    add_byte(8'h00, 17'd1, 1'b1, 1, '{64'haf63bd4c8601b7df, 16'd0, 17'd1, 1'b1});
    add_byte(8'hFF, 17'd3, 1'b0);
    add_byte(8'h80, 17'd3, 1'b0);
    add_byte(8'h7F, 17'd3, 1'b1);
    // divisor 1 cuts on every rolled byte: a cut on the last byte gives an empty tail
    add_cfg(rhcf_pkg::REG_BLOCK_DIVISOR, 16'd1);
    add_cfg(rhcf_pkg::REG_SKIP_COUNT, 16'd0);
    add_byte(8'h00, 17'd1, 1'b1, 2, '{64'haf63bd4c8601b7df, 16'd0, 17'd1, 1'b0},
             '{rhcf_pkg::FNV_BASIS, 16'd1, 17'd0, 1'b1});
    add_byte(8'h55, 17'd3, 1'b0);
    add_byte(8'hAA, 17'd3, 1'b0);
    add_byte(8'hFF, 17'd3, 1'b1);
    // longest skip; buffer ends inside it, then a zero length that never skips
    add_cfg(rhcf_pkg::REG_SKIP_COUNT, 16'd4095);
    add_byte(8'h01, 17'h1FFFF, 1'b0);
    add_byte(8'h02, 17'h1FFFF, 1'b0);
    add_byte(8'h03, 17'h1FFFF, 1'b1);
    add_byte(8'h10, 17'd0, 1'b0);
    add_byte(8'h20, 17'd0, 1'b1);
    // network mode: first chunk dropped, no tail
    add_cfg(rhcf_pkg::REG_NETWORK_MODE, 16'd1);
    add_cfg(rhcf_pkg::REG_SKIP_COUNT, 16'd0);
    add_byte(8'h3C, 17'd3, 1'b0);
    add_byte(8'hC3, 17'd3, 1'b0);
    add_byte(8'h5A, 17'd3, 1'b1);
    // zero divisor in network mode: nothing at all comes out
    add_cfg(rhcf_pkg::REG_BLOCK_DIVISOR, 16'd0);
    add_byte(8'hF0, 17'd2, 1'b0, 0);
    add_byte(8'h0F, 17'd2, 1'b1, 0);
    // write to the spare index must change nothing; then more bytes than stated
    add_cfg(REG_SPARE, 16'hFFFF);
    add_cfg(rhcf_pkg::REG_BLOCK_DIVISOR, 16'd2);
    add_cfg(rhcf_pkg::REG_NETWORK_MODE, 16'd0);
    add_cfg(rhcf_pkg::REG_SKIP_COUNT, 16'd1);
    add_byte(8'h01, 17'd1, 1'b0);
    add_byte(8'h02, 17'd1, 1'b0);
    add_byte(8'h03, 17'd1, 1'b1);
    // mode flipped in the middle of a buffer
    add_cfg(rhcf_pkg::REG_BLOCK_DIVISOR, 16'd1);
    add_cfg(rhcf_pkg::REG_SKIP_COUNT, 16'd0);
    add_byte(8'h11, 17'd2, 1'b0);
    add_cfg(rhcf_pkg::REG_NETWORK_MODE, 16'd1);
    add_byte(8'h22, 17'd2, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [rhcf_pkg::CFG_DATA_W-1:0] div_pick;
    logic [rhcf_pkg::SKIP_W-1:0]     skip_pick;
    logic                            net_pick;
    int                              phase;
    int                              nbuf;
    int                              r;

    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    data_byte     = '0;
    buffer_length = '0;
    last_byte     = 1'b0;
    out_stall     = 1'b0;
    pin_n         = -1;
    pin_a         = '0;
    pin_b         = '0;
    calm          = 1'b0;
    errors        = 0;
    random_bytes  = 0;
    cycle_cnt     = 0;
    stall_cnt     = 0;
    cfg_now       = '{16'd320, 12'd64, 1'b0};
    clear_buffer();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_table();
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        if (i == 0 || stim_rows[i-1].kind != ROW_CFG) settle_block();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        send_byte(stim_rows[i].d, stim_rows[i].blen, stim_rows[i].lst, stim_rows[i].npin,
                  stim_rows[i].pa, stim_rows[i].pb);
        idle_gap();
      end
    end

    // Random phases: fresh settings each phase, whole buffers only
    phase = 0;
    while (random_bytes < RANDOM_TARGET) begin
      settle_block();
      if (phase == 0) begin
        div_pick  = 16'hFFFF;
        skip_pick = 12'hFFF;
        net_pick  = 1'b0;
      end else begin
        r = $urandom_range(0, 19);
        case (r)
          0:       div_pick = 16'd0;
          1:       div_pick = 16'hFFFF;
          2:       div_pick = 16'd1;
          3:       div_pick = rhcf_pkg::CFG_DATA_W'($urandom_range(0, 16'hFFFF));
          default: div_pick = rhcf_pkg::CFG_DATA_W'($urandom_range(2, 48));
        endcase
        r = $urandom_range(0, 9);
        case (r)
          0:       skip_pick = 12'hFFF;
          1:       skip_pick = 12'd0;
          2:       skip_pick = rhcf_pkg::SKIP_W'($urandom_range(0, 12'hFFF));
          default: skip_pick = rhcf_pkg::SKIP_W'($urandom_range(0, 10));
        endcase
        net_pick = 1'($urandom_range(0, 1));
      end
      write_reg(rhcf_pkg::REG_BLOCK_DIVISOR, div_pick);
      write_reg(rhcf_pkg::REG_SKIP_COUNT, rhcf_pkg::CFG_DATA_W'(skip_pick));
      write_reg(rhcf_pkg::REG_NETWORK_MODE, rhcf_pkg::CFG_DATA_W'(net_pick));
      // every sixth phase runs with no idling on either side
      calm = (phase % 6 == 3);
      nbuf = $urandom_range(3, 10);
      repeat (nbuf) begin
        if ($urandom_range(0, 15) == 0) send_buffer($urandom_range(60, 160));
        else send_buffer($urandom_range(1, 24));
      end
      calm = 1'b0;
      phase++;
    end

    settle_block();
    if (errors == 0 && chunks_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
